[rtl/profile_edge_detector_unit_defines.svh]
// assertion macros used by the profile edge detector result buffer
`ifndef PROFILE_EDGE_DETECTOR_UNIT_DEFINES_SVH
`define PROFILE_EDGE_DETECTOR_UNIT_DEFINES_SVH

// property checked on every rising clk_i edge, off while rst_ni is low
`define PED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PED_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/ped_pkg.sv]
// constants and types of the profile edge detector
`timescale 1ns / 1ps

package ped_pkg;

  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned VAL_BITS   = 8;
  localparam int unsigned GRAD_BITS  = 9;
  localparam int unsigned MAG_BITS   = 8;
  localparam int unsigned THR_BITS   = 8;
  localparam int unsigned SEEN_BITS  = 3;
  localparam int unsigned TAPS       = 5;
  localparam int unsigned RAW_DEPTH  = 4;
  localparam int unsigned POS_DEPTH  = 4;
  localparam int unsigned EDGE_SLOTS = 4;
  localparam int unsigned NUM_SLOTS  = EDGE_SLOTS + 1;
  localparam int unsigned SLOT_BITS  = 3;
  localparam int unsigned SUM_BITS   = 2 * VAL_BITS;

  localparam int unsigned S_TDATA_W = ((POS_BITS + VAL_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((POS_BITS + GRAD_BITS + 7) / 8) * 8;

  localparam logic [SLOT_BITS-1:0] END_SLOT   = SLOT_BITS'(EDGE_SLOTS);
  localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(30);
  localparam logic [SEEN_BITS-1:0] SEEN_MAX   = '1;

  // q8 gaussian, sigma 1.1, sums to 256
  localparam logic [VAL_BITS-1:0] GAUSS_TAPS [TAPS] = '{
    VAL_BITS'(18), VAL_BITS'(62), VAL_BITS'(96), VAL_BITS'(62), VAL_BITS'(18)
  };

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic [VAL_BITS-1:0] value;
    logic                last;
  } sample_t;

  typedef struct packed {
    logic [POS_BITS-1:0]         pos;
    logic signed [GRAD_BITS-1:0] grad;
  } edge_t;

  // slot EDGE_SLOTS is the end marker, lower slots are edges oldest first
  typedef struct packed {
    logic [NUM_SLOTS-1:0]         valid;
    edge_t [EDGE_SLOTS-1:0]       edges;
  } bundle_t;

endpackage

[rtl/ped_detect.sv]
// sliding window, gaussian smoothing, gradient and peak test
`timescale 1ns / 1ps

module ped_detect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ped_pkg::sample_t                item_i,
  input  logic [ped_pkg::THR_BITS-1:0]    threshold_i,
  input  logic                            advance_i,
  output ped_pkg::bundle_t                bundle_o
);

  import ped_pkg::*;

  logic [VAL_BITS-1:0]         raw_q    [RAW_DEPTH];
  logic [VAL_BITS-1:0]         raw_d    [RAW_DEPTH];
  logic [POS_BITS-1:0]         pos_q    [POS_DEPTH];
  logic [POS_BITS-1:0]         pos_d    [POS_DEPTH];
  logic [VAL_BITS-1:0]         smooth_q, smooth_d;
  logic signed [GRAD_BITS-1:0] grad_q   [2];
  logic signed [GRAD_BITS-1:0] grad_d   [2];
  logic [SEEN_BITS-1:0]        seen_q, seen_d;

  logic [VAL_BITS-1:0]         win      [TAPS];
  logic [VAL_BITS-1:0]         sm       [3];
  logic [SUM_BITS-1:0]         sum_acc;
  logic [SUM_BITS-1:0]         prod;
  logic [2:0]                  idx;
  logic signed [GRAD_BITS-1:0] g        [5];
  logic                        last;

  // window index of one tap, mirrored at both profile ends
  function automatic logic [2:0] tap_idx(logic [SEEN_BITS-1:0] j, int m, int t,
                                         logic lst);
    int a;
    int jj;
    int w;
    logic done;
    jj   = int'(j);
    a    = jj - 2 + m + t;
    done = 1'b0;
    for (int n = 0; n < 6; n++) begin
      if (!done) begin
        if (a < 0) begin
          a = -a;
        end else if (lst && a > jj) begin
          a = 2 * jj - a;
        end else begin
          done = 1'b1;
        end
      end
    end
    if (a > jj) a = jj;
    if (a < 0) a = 0;
    w = a - jj + 4;
    if (w < 0) w = 0;
    if (w > 4) w = 4;
    return 3'(w);
  endfunction

  function automatic logic signed [GRAD_BITS-1:0] diff(logic [VAL_BITS-1:0] a,
                                                     logic [VAL_BITS-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [MAG_BITS-1:0] mag(logic signed [GRAD_BITS-1:0] v);
    logic [GRAD_BITS-1:0] n;
    n = v[GRAD_BITS-1] ? GRAD_BITS'(-v) : GRAD_BITS'(v);
    return n[MAG_BITS-1:0];
  endfunction

  function automatic logic is_edge(logic signed [GRAD_BITS-1:0] gl,
                                   logic signed [GRAD_BITS-1:0] gi,
                                   logic signed [GRAD_BITS-1:0] gr,
                                   logic [THR_BITS-1:0] thr);
    logic [MAG_BITS-1:0] m;
    m = mag(gi);
    return (m >= thr) && (m > mag(gl)) && (mag(gr) <= m);
  endfunction

  assign last = item_i.last;

  // smoothed values at samples j-2, j-1, j
  always_comb begin
    win[TAPS-1] = item_i.value;
    for (int i = 0; i < RAW_DEPTH; i++) begin
      win[i] = raw_q[RAW_DEPTH-1-i];
    end
    sum_acc = '0;
    prod    = '0;
    idx     = '0;
    for (int m = 0; m < 3; m++) begin
      sum_acc = '0;
      for (int t = 0; t < TAPS; t++) begin
        idx     = tap_idx(seen_q, m, t - 2, last);
        prod    = {{VAL_BITS{1'b0}}, GAUSS_TAPS[t]} * {{VAL_BITS{1'b0}}, win[idx]};
        sum_acc = sum_acc + prod;
      end
      sm[m] = sum_acc[SUM_BITS-1:VAL_BITS];
    end
  end

  // gradients at samples j-5 .. j-1
  always_comb begin
    g[0] = grad_q[1];
    g[1] = grad_q[0];
    g[2] = (seen_q >= SEEN_BITS'(3)) ? diff(smooth_q, sm[0]) : '0;
    g[3] = (last && seen_q >= SEEN_BITS'(2)) ? diff(sm[0], sm[1]) : '0;
    g[4] = (last && seen_q >= SEEN_BITS'(1)) ? diff(sm[1], sm[2]) : '0;
  end

  always_comb begin
    bundle_o.valid[0] = (seen_q >= SEEN_BITS'(4)) && is_edge(g[0], g[1], g[2], threshold_i);
    bundle_o.valid[1] = last && (seen_q >= SEEN_BITS'(3)) &&
                        is_edge(g[1], g[2], g[3], threshold_i);
    bundle_o.valid[2] = last && (seen_q >= SEEN_BITS'(2)) &&
                        is_edge(g[2], g[3], g[4], threshold_i);
    bundle_o.valid[3] = last && (seen_q >= SEEN_BITS'(1)) &&
                        is_edge(g[3], g[4], '0, threshold_i);
    bundle_o.valid[END_SLOT] = last;
    bundle_o.edges[0] = '{pos: pos_q[3], grad: g[1]};
    bundle_o.edges[1] = '{pos: pos_q[2], grad: g[2]};
    bundle_o.edges[2] = '{pos: pos_q[1], grad: g[3]};
    bundle_o.edges[3] = '{pos: pos_q[0], grad: g[4]};
  end

  // window update, cleared after the final sample of a profile
  always_comb begin
    raw_d    = raw_q;
    pos_d    = pos_q;
    smooth_d = smooth_q;
    grad_d   = grad_q;
    seen_d   = seen_q;
    if (advance_i) begin
      if (last) begin
        for (int i = 0; i < RAW_DEPTH; i++) raw_d[i] = '0;
        for (int i = 0; i < POS_DEPTH; i++) pos_d[i] = '0;
        smooth_d  = '0;
        grad_d[0] = '0;
        grad_d[1] = '0;
        seen_d    = '0;
      end else begin
        raw_d[0] = item_i.value;
        pos_d[0] = item_i.pos;
        for (int i = 1; i < RAW_DEPTH; i++) raw_d[i] = raw_q[i-1];
        for (int i = 1; i < POS_DEPTH; i++) pos_d[i] = pos_q[i-1];
        if (seen_q >= SEEN_BITS'(3)) begin
          grad_d[1] = grad_q[0];
          grad_d[0] = g[2];
        end
        if (seen_q >= SEEN_BITS'(2)) begin
          smooth_d = sm[0];
        end
        if (seen_q != SEEN_MAX) begin
          seen_d = seen_q + SEEN_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RAW_DEPTH; i++) raw_q[i] <= '0;
      for (int i = 0; i < POS_DEPTH; i++) pos_q[i] <= '0;
      smooth_q  <= '0;
      grad_q[0] <= '0;
      grad_q[1] <= '0;
      seen_q    <= '0;
    end else begin
      raw_q    <= raw_d;
      pos_q    <= pos_d;
      smooth_q <= smooth_d;
      grad_q   <= grad_d;
      seen_q   <= seen_d;
    end
  end

endmodule

[rtl/ped_result_buf.sv]
// result register holding one item's edges and end marker, sent oldest first
`timescale 1ns / 1ps
`include "profile_edge_detector_unit_defines.svh"

module ped_result_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ped_pkg::bundle_t      bundle_i,
  input  logic                  load_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  logic                  taken_i,
  output ped_pkg::edge_t        edge_o,
  output logic                  end_o
);

  import ped_pkg::*;

  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  edge_t                edges_q [EDGE_SLOTS];
  logic [SLOT_BITS-1:0] sel;
  logic                 found;
  logic                 take;
  logic                 end_sel;

  // lowest pending slot goes out first
  always_comb begin
    sel   = END_SLOT;
    found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (valid_q[i] && !found) begin
        sel   = SLOT_BITS'(i);
        found = 1'b1;
      end
    end
  end

  assign valid_o = |valid_q;
  assign take    = valid_o && taken_i;
  assign end_sel = (sel == END_SLOT);
  assign ready_o = (valid_q == '0) || ($onehot(valid_q) && take);
  assign end_o   = end_sel;
  assign edge_o  = end_sel ? edge_t'('0) : edges_q[sel[1:0]];

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = bundle_i.valid;
    end else if (take) begin
      valid_d = valid_q & ~(NUM_SLOTS'(1) << sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < EDGE_SLOTS; i++) edges_q[i] <= bundle_i.edges[i];
    end
  end

  `PED_ASSERT(a_no_adjacent_edges, load_i |-> !(bundle_i.valid[0] && bundle_i.valid[1]) && !(bundle_i.valid[1] && bundle_i.valid[2]) && !(bundle_i.valid[2] && bundle_i.valid[3]), "two neighbouring samples flagged as edges")
  `PED_ASSERT(a_flush_has_marker, load_i && (bundle_i.valid[EDGE_SLOTS-1:1] != '0) |-> bundle_i.valid[END_SLOT], "flushed edges without end marker")
  `PED_ASSERT(a_marker_is_final, take && end_sel |-> $onehot(valid_q), "end marker sent before pending edges")
  `PED_ASSERT_NEVER(a_load_over_pending, load_i && !ready_o, "result register overwritten with transfers pending")
  `PED_ASSERT(a_pending_held, valid_o && !taken_i |=> $stable(valid_q), "pending slots changed without a transfer")

endmodule

[rtl/profile_edge_detector_unit.sv]
// top level of the profile edge detector with stream ports and threshold register
`timescale 1ns / 1ps
// path: an input transfer passes the input register, then the result register, to the master side
// throughput: one sample per cycle while each sample yields at most one result and the master side
// takes every result; the final sample of a profile holds the input until the result register has
// sent all of its results (up to 3 results: at most two flushed edges and the end marker)
// reset: window state and handshakes cleared, edge threshold back to 30

module profile_edge_detector_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_wr_en_i,
  input  logic [ped_pkg::THR_BITS-1:0]    cfg_wr_data_i,     // edge_threshold
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [ped_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,    // sample_pos, sample_value
  input  logic                            s_axis_tlast_i,    // is_last
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [ped_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,    // edge_pos, edge_gradient
  output logic                            m_axis_tlast_o     // end_of_profile
);

  import ped_pkg::*;

  logic                in_valid_q;
  sample_t             in_q;
  logic [THR_BITS-1:0] thr_q;
  logic                buf_ready;
  logic                advance;
  bundle_t             bundle;
  edge_t               out_edge;

  assign advance         = in_valid_q && buf_ready;
  assign s_axis_tready_o = !in_valid_q || buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      thr_q      <= THR_RESET;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.pos   <= s_axis_tdata_i[POS_BITS-1:0];
      in_q.value <= s_axis_tdata_i[POS_BITS +: VAL_BITS];
      in_q.last  <= s_axis_tlast_i;
    end
  end

  ped_detect u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_q),
    .threshold_i (thr_q),
    .advance_i   (advance),
    .bundle_o    (bundle)
  );

  ped_result_buf u_result_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (bundle),
    .load_i   (advance),
    .ready_o  (buf_ready),
    .valid_o  (m_axis_tvalid_o),
    .taken_i  (m_axis_tready_i),
    .edge_o   (out_edge),
    .end_o    (m_axis_tlast_o)
  );

  always_comb begin
    m_axis_tdata_o                          = '0;
    m_axis_tdata_o[POS_BITS-1:0]            = out_edge.pos;
    m_axis_tdata_o[POS_BITS +: GRAD_BITS]   = out_edge.grad;
  end

endmodule

[tb/testbench.sv]
// self-checking testbench for the profile edge detector: directed and random profiles
`timescale 1ns / 1ps

module testbench;
  import ped_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 55;

  typedef struct packed {
    logic [POS_BITS-1:0]         pos;
    logic signed [GRAD_BITS-1:0] grad;
    logic                        eop;
  } edge_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [THR_BITS-1:0]  cfg_wr_data = '0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic                 s_last = 1'b0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;
  logic                 m_last;

  // predictor state
  logic [THR_BITS-1:0] thr_model = THR_RESET;
  logic [VAL_BITS-1:0] raw_hist [4];
  logic [POS_BITS-1:0] pos_hist [5];
  int                  smooth_last;
  int                  grad_hist [2];
  int                  seen;

  sample_t      samples_pending [$];
  edge_report_t edges_due [$];
  sample_t      in_flight;
  edge_report_t due;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int samples_queued = 0;
  int samples_taken = 0;
  int profiles_done = 0;
  int edges_checked = 0;
  int ends_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;

  profile_edge_detector_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_profile();
    for (int i = 0; i < 4; i++) raw_hist[i] = '0;
    for (int i = 0; i < 5; i++) pos_hist[i] = '0;
    smooth_last = 0;
    grad_hist[0] = 0;
    grad_hist[1] = 0;
    seen = 0;
  endtask

  // reflected 5-tap gaussian at sample k; win holds samples j-4 (low byte) to j
  function automatic int gauss_smooth(logic [5*VAL_BITS-1:0] win, int k, int j, bit last);
    int sum, a, idx, w;
    bit settled;
    sum = 0;
    for (int t = -2; t <= 2; t++) begin
      a = k + t;
      settled = 1'b0;
      for (int n = 0; n < 6 && !settled; n++) begin
        if (a < 0) a = -a;
        else if (last && a > j) a = 2 * j - a;
        else settled = 1'b1;
      end
      if (a > j) a = j;
      if (a < 0) a = 0;
      idx = a - j + 4;
      if (idx < 0) idx = 0;
      if (idx > 4) idx = 4;
      w = (t == 0) ? 96 : ((t == 1 || t == -1) ? 62 : 18);
      sum += w * int'(win[idx*VAL_BITS +: VAL_BITS]);
    end
    return sum / 256;
  endfunction

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit is_peak(int gl, int gi, int gr);
    return mag(gi) >= int'(thr_model) && mag(gi) > mag(gl) && mag(gr) <= mag(gi);
  endfunction

  task automatic report_edge(logic [POS_BITS-1:0] pos, int grad, bit eop);
    edge_report_t r;
    r.pos  = pos;
    r.grad = GRAD_BITS'(grad);
    r.eop  = eop;
    edges_due = {edges_due, r};
  endtask

  task automatic predict_edges(sample_t smp);
    logic [5*VAL_BITS-1:0] win;
    int s [3];
    int g [7];
    int j, k;
    j = seen;
    win = {smp.value, raw_hist[0], raw_hist[1], raw_hist[2], raw_hist[3]};
    for (int i = 4; i > 0; i--) pos_hist[i] = pos_hist[i-1];
    pos_hist[0] = smp.pos;
    for (int i = 0; i < 3; i++) begin
      k = j - 2 + i;
      s[i] = (k >= 0 && (i == 0 || smp.last)) ? gauss_smooth(win, k, j, smp.last) : 0;
    end
    for (int i = 0; i < 7; i++) g[i] = 0;
    g[0] = grad_hist[1];
    g[1] = grad_hist[0];
    if (j >= 3) g[2] = smooth_last - s[0];
    if (smp.last && j >= 2) g[3] = s[0] - s[1];
    if (smp.last && j >= 1) g[4] = s[1] - s[2];
    if (j >= 4 && is_peak(g[0], g[1], g[2])) report_edge(pos_hist[4], g[1], 1'b0);
    if (smp.last) begin
      for (int i = 2; i <= 5; i++) begin
        if (j - 5 + i >= 0 && is_peak(g[i-1], g[i], g[i+1]))
          report_edge(pos_hist[5-i], g[i], 1'b0);
      end
      report_edge('0, 0, 1'b1);
      clear_profile();
    end else begin
      raw_hist[3] = raw_hist[2];
      raw_hist[2] = raw_hist[1];
      raw_hist[1] = raw_hist[0];
      raw_hist[0] = smp.value;
      if (j >= 3) begin
        grad_hist[1] = grad_hist[0];
        grad_hist[0] = g[2];
      end
      if (j >= 2) smooth_last = s[0];
      if (seen < 7) seen++;
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic push_sample(logic [POS_BITS-1:0] pos, logic [VAL_BITS-1:0] value, bit last);
    sample_t smp;
    smp.pos   = pos;
    smp.value = value;
    smp.last  = last;
    samples_pending = {samples_pending, smp};
    samples_queued++;
  endtask

  function automatic int pick_level();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // mostly flat levels with steps and light noise, some pure noise, very short and long profiles
  task automatic queue_random_profile();
    int style, len, lvl, noise, val;
    logic [POS_BITS-1:0] pos;
    style = $urandom_range(9);
    if (style == 0) len = $urandom_range(1, 3);
    else if (style == 9) len = $urandom_range(24, 40);
    else len = $urandom_range(4, 16);
    pos = POS_BITS'($urandom);
    lvl = pick_level();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(4) == 0) lvl = pick_level();
      noise = $urandom_range(6);
      val = (style == 1) ? $urandom_range(255) : lvl + noise - 3;
      if (val < 0) val = 0;
      if (val > 255) val = 255;
      push_sample(pos, VAL_BITS'(val), i == len - 1);
      pos = pos + POS_BITS'($urandom_range(1, 3));
    end
  endtask

  task automatic wait_drained();
    while (samples_taken != samples_queued || edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_BITS-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    thr_model = value;
  endtask

  // input side: one transfer per handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_valid && s_ready) begin
        predict_edges(in_flight);
        samples_taken++;
        if (in_flight.last) profiles_done++;
      end
      if (!s_valid || s_ready) begin
        if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = samples_pending.pop_front();
          s_valid <= 1'b1;
          s_data  <= S_TDATA_W'({in_flight.value, in_flight.pos});
          s_last  <= in_flight.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (edges_due.size() == 0) begin
        $error("unexpected result: pos %0d grad %0d end %0b", m_data[POS_BITS-1:0],
               $signed(m_data[POS_BITS +: GRAD_BITS]), m_last);
        fail_count++;
      end else begin
        due = edges_due.pop_front();
        check_field("edge_pos", due.pos, m_data[POS_BITS-1:0]);
        check_field("edge_gradient", $signed(due.grad), $signed(m_data[POS_BITS +: GRAD_BITS]));
        check_field("end_of_profile", due.eop, m_last);
        if (due.eop) ends_checked++;
        else edges_checked++;
      end
    end
    m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int target;
    clear_profile();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed profiles at the reset threshold
    push_sample(16'hFFFF, 8'hFF, 1'b1);
    push_sample(16'h0000, 8'h00, 1'b0);
    push_sample(16'h0001, 8'hFF, 1'b1);
    push_sample(16'h0064, 8'hFF, 1'b0);
    push_sample(16'h0065, 8'h00, 1'b0);
    push_sample(16'h0066, 8'hFF, 1'b1);
    for (int i = 0; i < 6; i++)
      push_sample(POS_BITS'(16'h8000 + i), (i == 0) ? 8'hFF : 8'h00, i == 5);
    for (int i = 0; i < 8; i++)
      push_sample(POS_BITS'(16'h7FF8 + i), (i < 4) ? 8'h00 : 8'hFF, i == 7);
    for (int i = 0; i < 5; i++)
      push_sample(POS_BITS'(16'h5555 + i), (i < 4) ? 8'h00 : 8'hFF, i == 4);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_threshold(8'd0);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_threshold(8'd255);
          send_idle_pct = 46;
          recv_stall_pct = 0;
        end
        2: begin
          write_threshold(THR_BITS'($urandom_range(10, 60)));
          send_idle_pct = 0;
          recv_stall_pct = 46;
        end
        default: begin
          write_threshold(THR_BITS'($urandom_range(1, 254)));
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
      endcase
      target = samples_queued + PHASE_ITEMS;
      while (samples_queued < target) queue_random_profile();
      if (ph == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d samples in %0d profiles over five thresholds, 0 and 255 included,",
             samples_taken, profiles_done);
    $display("with idle and stall phases; %0d edges and %0d end markers checked",
             edges_checked, ends_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
